[rtl/core/probe_request_frame_parser_top_defines.svh]
// ----------------------------------------------------------------------------
// Probe request parser assertion macros
// Shared concurrent assertion shorthands. Every user has clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef PROBE_REQUEST_FRAME_PARSER_TOP_DEFINES_SVH
`define PROBE_REQUEST_FRAME_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRFP_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRFP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/prfp_pkg.sv]
// ----------------------------------------------------------------------------
// Probe request parser package
// Beat types, queue record type and fixed protocol constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prfp_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] frame_length;
        logic        last_byte;
    } item_t;

    typedef struct packed {
        logic              result_kind;
        logic [7:0]        ssid_char;
        logic [4:0]        char_index;
        logic              frame_valid;
        logic [47:0]       source_mac;
        logic signed [7:0] signal_strength;
        logic [5:0]        ssid_length;
        logic              broadcast_ssid;
        logic              end_of_run;
    } result_t;

    typedef struct packed {
        logic              frame_valid;
        logic [47:0]       source_mac;
        logic signed [7:0] signal_strength;
        logic [5:0]        ssid_length;
        logic              broadcast_ssid;
    } summary_t;

    // One queue record holds everything a single input byte produces.
    typedef struct packed {
        logic       has_char;
        logic [7:0] ssid_char;
        logic [4:0] char_index;
        logic       has_summary;
        summary_t   summary;
    } record_t;

    localparam logic [7:0]  FC_PROBE_REQ = 8'h40;
    localparam logic [7:0]  FC_FLAGS     = 8'h00;
    localparam logic [7:0]  SSID_TAG     = 8'h00;
    localparam logic [7:0]  PRINT_LOW    = 8'h20;
    localparam logic [7:0]  PRINT_END    = 8'h7F;
    localparam logic [7:0]  SUB_CHAR     = 8'h2E;
    localparam logic [5:0]  SSID_MAX     = 6'd32;
    localparam logic [11:0] MIN_LEN      = 12'd60;
    localparam int          ELEM_OFFSET  = 24;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

endpackage

`default_nettype wire

[rtl/core/prfp_parser.sv]
// ----------------------------------------------------------------------------
// Probe request parser front end
// Walks the capture byte by byte and builds one queue record per byte
// that yields an SSID character or the frame summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "probe_request_frame_parser_top_defines.svh"

module prfp_parser import prfp_pkg::*; #(
    parameter int HEADER_BYTES    = 36,
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    take,
    output record_t rec,
    output logic    rec_push
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam int CW    = ((POS_W > 12) ? POS_W : 12) + 2;

    localparam logic [CW-1:0]    HB       = CW'(HEADER_BYTES);
    localparam logic [CW-1:0]    HB_FLAGS = CW'(HEADER_BYTES + 1);
    localparam logic [CW-1:0]    ADDR_LO  = CW'(HEADER_BYTES + 10);
    localparam logic [CW-1:0]    ADDR_HI  = CW'(HEADER_BYTES + 16);
    localparam logic [CW-1:0]    ELEM_LO  = CW'(HEADER_BYTES + ELEM_OFFSET);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_BYTES - 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_SSID   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              ctrl_reg, ctrl_next;
    logic [7:0]        strength_reg, strength_next;
    logic [47:0]       addr_reg, addr_next;
    logic [2:0]        phase_reg, phase_next;
    logic              tag_zero_reg, tag_zero_next;
    logic [7:0]        rem_reg, rem_next;
    logic [5:0]        chars_reg, chars_next;
    logic              seen_reg, seen_next;
    logic              empty_reg, empty_next;

    logic [CW-1:0]     p_w, len_w, b_w;
    logic              emit_char;
    logic [7:0]        char_out;
    logic [4:0]        idx_out;
    summary_t          sum_out;

    assign p_w   = CW'(pos_reg);
    assign len_w = CW'(item.frame_length);
    assign b_w   = CW'(item.data_byte);

    always_comb
    begin
        pos_next      = pos_reg;
        ctrl_next     = ctrl_reg;
        strength_next = strength_reg;
        addr_next     = addr_reg;
        phase_next    = phase_reg;
        tag_zero_next = tag_zero_reg;
        rem_next      = rem_reg;
        chars_next    = chars_reg;
        seen_next     = seen_reg;
        empty_next    = empty_reg;
        emit_char     = 1'b0;
        char_out      = '0;
        idx_out       = '0;
        sum_out       = '0;

        if (p_w == '0)
        begin
            strength_next = item.data_byte;
        end
        if (p_w >= ADDR_LO && p_w < ADDR_HI)
        begin
            addr_next = {addr_reg[39:0], item.data_byte};
        end
        if (p_w == HB)
        begin
            ctrl_next = (item.data_byte == FC_PROBE_REQ);
        end
        if (p_w == HB_FLAGS)
        begin
            ctrl_next = ctrl_next && (item.data_byte == FC_FLAGS)
                        && (item.frame_length >= MIN_LEN);
        end

        if (ctrl_next && p_w >= ELEM_LO && p_w < len_w)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (p_w + CW'(1) < len_w)
                    begin
                        tag_zero_next = (item.data_byte == SSID_TAG);
                        phase_next    = PH_LENGTH;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_LENGTH:
                begin
                    if (p_w + CW'(1) + b_w > len_w)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (tag_zero_reg)
                    begin
                        seen_next = 1'b1;
                        if (item.data_byte == 8'd0)
                        begin
                            empty_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            rem_next   = item.data_byte;
                            phase_next = PH_SSID;
                        end
                    end
                    else if (item.data_byte == 8'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        rem_next   = item.data_byte;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    rem_next = rem_reg - 8'd1;
                    if (rem_reg == 8'd1)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_SSID:
                begin
                    if (chars_reg < SSID_MAX)
                    begin
                        emit_char  = 1'b1;
                        char_out   = (item.data_byte >= PRINT_LOW && item.data_byte < PRINT_END)
                                     ? item.data_byte : SUB_CHAR;
                        idx_out    = chars_reg[4:0];
                        chars_next = chars_reg + 6'd1;
                    end
                    rem_next = rem_reg - 8'd1;
                    if (rem_reg == 8'd1)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (item.last_byte)
        begin
            sum_out.frame_valid     = ctrl_next && seen_next;
            sum_out.source_mac      = addr_next;
            sum_out.signal_strength = strength_next;
            sum_out.ssid_length     = chars_next;
            sum_out.broadcast_ssid  = empty_next;
            // The next capture starts from a clean slate.
            pos_next      = '0;
            ctrl_next     = 1'b0;
            strength_next = '0;
            addr_next     = '0;
            phase_next    = PH_HEADER;
            tag_zero_next = 1'b0;
            rem_next      = '0;
            chars_next    = '0;
            seen_next     = 1'b0;
            empty_next    = 1'b0;
        end
        else if (pos_reg < POS_LAST)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            ctrl_reg     <= 1'b0;
            strength_reg <= '0;
            addr_reg     <= '0;
            phase_reg    <= PH_HEADER;
            tag_zero_reg <= 1'b0;
            rem_reg      <= '0;
            chars_reg    <= '0;
            seen_reg     <= 1'b0;
            empty_reg    <= 1'b0;
        end
        else if (take)
        begin
            pos_reg      <= pos_next;
            ctrl_reg     <= ctrl_next;
            strength_reg <= strength_next;
            addr_reg     <= addr_next;
            phase_reg    <= phase_next;
            tag_zero_reg <= tag_zero_next;
            rem_reg      <= rem_next;
            chars_reg    <= chars_next;
            seen_reg     <= seen_next;
            empty_reg    <= empty_next;
        end
    end

    always_comb
    begin
        rec.has_char    = emit_char;
        rec.ssid_char   = char_out;
        rec.char_index  = idx_out;
        rec.has_summary = item.last_byte;
        rec.summary     = sum_out;
    end

    assign rec_push = take && (emit_char || item.last_byte);

    `PRFP_ASSERT_SAME(a_char_phase, rec.has_char, phase_reg == PH_SSID, "char outside SSID")
    `PRFP_ASSERT_SAME(a_char_count, rec.has_char, chars_reg < SSID_MAX, "char past SSID limit")

endmodule

`default_nettype wire

[rtl/core/prfp_queue.sv]
// ----------------------------------------------------------------------------
// Probe request parser record queue
// Small first-in first-out buffer between the parser and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "probe_request_frame_parser_top_defines.svh"

module prfp_queue import prfp_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  record_t wdata,
    output logic    full,
    input  logic    rd,
    output record_t rdata,
    output logic    empty
);

    record_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     cnt_reg;
    logic                  do_wr, do_rd;

    assign full  = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + (QUEUE_AW+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

    `PRFP_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH), "overflow")
    `PRFP_ASSERT_NEXT(a_cnt_inc, do_wr && !do_rd, cnt_reg == $past(cnt_reg) + 1'b1, "lost write")

endmodule

`default_nettype wire

[rtl/core/prfp_emitter.sv]
// ----------------------------------------------------------------------------
// Probe request parser back end
// Expands queue records into result beats held in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "probe_request_frame_parser_top_defines.svh"

module prfp_emitter import prfp_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  record_t head,
    input  logic    head_valid,
    output logic    head_pop,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    logic     out_valid_reg, out_valid_next;
    result_t  out_reg, out_next;
    logic     pend_reg, pend_next;
    summary_t pend_sum_reg, pend_sum_next;
    logic     free;
    logic     pend_held;

    function automatic result_t summary_beat(input summary_t s);
        result_t r;
        r                 = '0;
        r.result_kind     = KIND_SUMMARY;
        r.frame_valid     = s.frame_valid;
        r.source_mac      = s.source_mac;
        r.signal_strength = s.signal_strength;
        r.ssid_length     = s.ssid_length;
        r.broadcast_ssid  = s.broadcast_ssid;
        r.end_of_run      = 1'b1;
        return r;
    endfunction

    assign free = !out_valid_reg || pop;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;
        pend_sum_next  = pend_sum_reg;
        head_pop       = 1'b0;
        if (free)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = summary_beat(pend_sum_reg);
                pend_next      = 1'b0;
            end
            else if (head_valid)
            begin
                head_pop       = 1'b1;
                out_valid_next = 1'b1;
                if (head.has_char)
                begin
                    out_next             = '0;
                    out_next.result_kind = KIND_CHAR;
                    out_next.ssid_char   = head.ssid_char;
                    out_next.char_index  = head.char_index;
                    out_next.end_of_run  = !head.has_summary;
                    pend_next            = head.has_summary;
                    pend_sum_next        = head.summary;
                end
                else
                begin
                    out_next = summary_beat(head.summary);
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        pend_sum_reg <= pend_sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    // A held summary always sits behind its character beat.
    assign pend_held = out_valid_reg && out_reg.result_kind == KIND_CHAR && !out_reg.end_of_run;

    `PRFP_ASSERT_SAME(a_pend_behind_char, pend_reg, pend_held, "summary pending alone")

endmodule

`default_nettype wire

[rtl/core/probe_request_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// Probe request frame parser, top level
// Path: a taken byte's record is written into the queue, then moved into the output register.
// Throughput: one byte per cycle, set by the parser, while the queue is not full; a byte that ends an SSID
// and the capture gives two beats, and a four-record queue absorbs that.
// Reset: asynchronous active-low rst_n clears the parse state and empties all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module probe_request_frame_parser_top import prfp_pkg::*; #(
    parameter int HEADER_BYTES    = 36,
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    push,
    output logic    full,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    // The front end parses each accepted byte in the cycle it arrives. Only
    // bytes that produce something (an SSID character, the summary, or both)
    // leave a record in the queue, so most header bytes cost no queue space.
    // Input back-pressure comes straight from the queue: when it is full, the
    // parser holds its state and the sender keeps the byte.

    logic    take;
    logic    q_full;
    logic    q_empty;
    logic    q_rd;
    logic    rec_push;
    record_t rec;
    record_t q_head;

    assign full = q_full;
    assign take = push && !q_full;

    prfp_parser #(
        .HEADER_BYTES    (HEADER_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .take     (take),
        .rec      (rec),
        .rec_push (rec_push)
    );

    // The queue decouples parsing from delivery, so a stalled consumer does
    // not stop bytes from coming in until four records are waiting.
    prfp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (rec_push),
        .wdata (rec),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_head),
        .empty (q_empty)
    );

    // The back end turns each record into one or two result beats. Its
    // output register is the only thing the consumer sees, and it refills in
    // the same cycle a beat is popped, so delivery runs one beat per cycle while records wait.
    prfp_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (!q_empty),
        .head_pop   (q_rd),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

`default_nettype wire
